### hw/rtl/xtea_pkg.sv
// Shared types, constants and round functions for the XTEA block cipher.
`default_nettype none

package xtea_pkg;

  localparam logic [31:0] DELTA      = 32'h9E37_79B9;
  localparam int          KEY_SHIFT  = 11;
  localparam int          WORD_W     = 32;
  localparam int          ROUND_W    = 7;
  localparam int          CFG_IDX_W  = 3;

  localparam logic [ROUND_W-1:0] ROUND_RESET = 7'd32;
  // delta times the reset round count, modulo 2^32
  localparam logic [WORD_W-1:0]  DEC_SUM_RESET = WORD_W'(DELTA * 32'd32);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND = 3'd4;

  // operation codes
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] block_first;
    logic [WORD_W-1:0] block_second;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_first;
    logic [WORD_W-1:0] result_second;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;      // capture a request and reset the round counter
    logic step;      // run one Feistel cycle
    logic load_out;  // move the finished block into the output register
  } cmd_t;

  typedef struct packed {
    logic rounds_zero; // configured round count is zero
    logic last_round;  // one Feistel cycle left
    logic out_free;    // output register can take a block this cycle
  } sts_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
    mix = ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // one half-round term: mixed word xor (sum + key word)
  function automatic logic [WORD_W-1:0] half_term(input logic [WORD_W-1:0] w,
                                                  input logic [WORD_W-1:0] sum,
                                                  input logic [WORD_W-1:0] key);
    half_term = mix(w) ^ (sum + key);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/xtea_ctrl.sv
// Sequencing state machine for the XTEA block cipher.
`default_nettype none

module xtea_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire xtea_pkg::sts_t   sts,
  output xtea_pkg::cmd_t        cmd
);

  xtea_pkg::state_t state;
  xtea_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xtea_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      xtea_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.rounds_zero ? xtea_pkg::ST_FLUSH : xtea_pkg::ST_ROUND;
        end
      end
      xtea_pkg::ST_ROUND: begin
        if (sts.last_round) begin
          state_next = xtea_pkg::ST_FLUSH;
        end
      end
      xtea_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          state_next = xtea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xtea_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      xtea_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      xtea_pkg::ST_ROUND: begin
        cmd.step = 1'b1;
      end
      xtea_pkg::ST_FLUSH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/xtea_datapath.sv
// Key and round registers, Feistel round unit and output register for XTEA.
`default_nettype none

module xtea_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr,
  input  wire logic [xtea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [xtea_pkg::WORD_W-1:0]         cfg_data,
  input  wire xtea_pkg::in_t                       in_data,
  input  wire xtea_pkg::cmd_t                      cmd,
  output xtea_pkg::sts_t                           sts,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output xtea_pkg::out_t                           out_data
);

  logic [xtea_pkg::WORD_W-1:0]  key [4];
  logic [xtea_pkg::ROUND_W-1:0] round_count;
  logic [xtea_pkg::WORD_W-1:0]  dec_sum;

  logic                         func;
  logic [xtea_pkg::WORD_W-1:0]  v0;
  logic [xtea_pkg::WORD_W-1:0]  v1;
  logic [xtea_pkg::WORD_W-1:0]  sum;
  logic [xtea_pkg::ROUND_W-1:0] count;

  logic [xtea_pkg::WORD_W-1:0]  v0_next;
  logic [xtea_pkg::WORD_W-1:0]  v1_next;
  logic [xtea_pkg::WORD_W-1:0]  sum_next;

  // configuration; the decryption start sum is worked out at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]      <= '0;
      key[1]      <= '0;
      key[2]      <= '0;
      key[3]      <= '0;
      round_count <= xtea_pkg::ROUND_RESET;
      dec_sum     <= xtea_pkg::DEC_SUM_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        xtea_pkg::REG_KEY0:  key[0] <= cfg_data;
        xtea_pkg::REG_KEY1:  key[1] <= cfg_data;
        xtea_pkg::REG_KEY2:  key[2] <= cfg_data;
        xtea_pkg::REG_KEY3:  key[3] <= cfg_data;
        xtea_pkg::REG_ROUND: begin
          round_count <= cfg_data[xtea_pkg::ROUND_W-1:0];
          dec_sum     <= xtea_pkg::WORD_W'(xtea_pkg::DELTA *
                         xtea_pkg::WORD_W'(cfg_data[xtea_pkg::ROUND_W-1:0]));
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // one full Feistel cycle, forward or backward
  always_comb begin
    if (func == xtea_pkg::FUNC_ENC) begin
      sum_next = sum + xtea_pkg::DELTA;
      v0_next  = v0 + xtea_pkg::half_term(v1, sum, key[sum[1:0]]);
      v1_next  = v1 + xtea_pkg::half_term(v0_next, sum_next,
                 key[sum_next[xtea_pkg::KEY_SHIFT+1:xtea_pkg::KEY_SHIFT]]);
    end else begin
      sum_next = sum - xtea_pkg::DELTA;
      v1_next  = v1 - xtea_pkg::half_term(v0, sum,
                 key[sum[xtea_pkg::KEY_SHIFT+1:xtea_pkg::KEY_SHIFT]]);
      v0_next  = v0 - xtea_pkg::half_term(v1_next, sum_next, key[sum_next[1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func  <= in_data.func;
      v0    <= in_data.block_first;
      v1    <= in_data.block_second;
      sum   <= (in_data.func == xtea_pkg::FUNC_DEC) ? dec_sum : '0;
      count <= round_count;
    end else if (cmd.step) begin
      v0    <= v0_next;
      v1    <= v1_next;
      sum   <= sum_next;
      count <= count - xtea_pkg::ROUND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.result_first  <= v0;
      out_data.result_second <= v1;
    end
  end

  assign sts.rounds_zero = (round_count == '0);
  assign sts.last_round  = (count == xtea_pkg::ROUND_W'(1));
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

`default_nettype wire

### hw/rtl/xtea_block_cipher.sv
// Top level of the XTEA block cipher: 64-bit block, 128-bit key, iterative round unit.
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_stall    in_data   (func, block_first, block_second)
// out       result     out_valid / out_stall  out_data  (result_first, result_second)
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Flow: a request is captured, runs one Feistel cycle per clock through the single round
//   unit, then is handed off to the output register.
// One request is in flight at a time; in_stall is high from capture until hand-off.
// The output register frees the round unit: a finished block waits there while the
//   next request is captured, but a second finished block waits in the round unit.
// Reset (synchronous, rst high) clears the key to zero and round_count to 32.
// Configuration writes are always accepted; write them only while the block is idle.

module xtea_block_cipher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [xtea_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire xtea_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output xtea_pkg::out_t                      out_data
);

  xtea_pkg::cmd_t cmd;
  xtea_pkg::sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequence capture, rounds and hand-off
  xtea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold key and round count, run the rounds, hold the result
  xtea_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a captured request keeps the input side stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a request was captured");

  // a hand-off always shows up as a valid result
  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("hand-off did not raise out_valid");

  // a result appears only through a hand-off
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without a hand-off");

  // never run a round and capture a request at once
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!cmd.step && !cmd.load_out))
    else $error("capture overlaps round or hand-off");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the XTEA block cipher: predicted blocks versus the cipher's output.
`timescale 1ns / 100ps

module tb;

  // No acceptance on any channel for this many cycles means the block has hung.
  // The longest quiet stretch in a correct run is the long output hold (LONG_HOLD)
  // with the block full, or one block at 127 rounds plus the longest stall and gap.
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  // 127 rounds is the worst case for one request
  localparam int TAIL_CYCLES    = 140;
  localparam int SEGMENTS       = 20;
  localparam int SEGMENT_ITEMS  = 40;

  // Scoreboard: keeps its own copy of the key and round count, predicts each
  // accepted request and checks the results in order.
  class xtea_expect_board;
    logic [xtea_pkg::WORD_W-1:0]  key_word [4];
    logic [xtea_pkg::ROUND_W-1:0] rounds;
    xtea_pkg::out_t               expected_q [$];
    int                           fails;
    int                           checked;
    int                           enc_seen;
    int                           dec_seen;

    function new();
      key_word = '{default: '0};
      rounds   = xtea_pkg::ROUND_RESET;
      fails    = 0;
      checked  = 0;
      enc_seen = 0;
      dec_seen = 0;
    endfunction

    // indexes beyond the round count register are ignored by the block
    function void write_reg(logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                            logic [xtea_pkg::WORD_W-1:0] value);
      if (idx <= xtea_pkg::REG_KEY3)
        key_word[idx[1:0]] = value;
      else if (idx == xtea_pkg::REG_ROUND)
        rounds = value[xtea_pkg::ROUND_W-1:0];
    endfunction

    function logic [xtea_pkg::WORD_W-1:0] feistel_mix(logic [xtea_pkg::WORD_W-1:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function xtea_pkg::out_t cipher(xtea_pkg::in_t req);
      logic [xtea_pkg::WORD_W-1:0] v0;
      logic [xtea_pkg::WORD_W-1:0] v1;
      logic [xtea_pkg::WORD_W-1:0] sum;
      xtea_pkg::out_t              res;
      v0 = req.block_first;
      v1 = req.block_second;
      if (req.func == xtea_pkg::FUNC_ENC) begin
        sum = '0;
        for (int i = 0; i < int'(rounds); i++) begin
          v0 += feistel_mix(v1) ^ (sum + key_word[sum[1:0]]);
          sum += xtea_pkg::DELTA;
          v1 += feistel_mix(v0) ^ (sum + key_word[sum[xtea_pkg::KEY_SHIFT +: 2]]);
        end
      end else begin
        sum = xtea_pkg::DELTA * {25'd0, rounds};
        for (int i = 0; i < int'(rounds); i++) begin
          v1 -= feistel_mix(v0) ^ (sum + key_word[sum[xtea_pkg::KEY_SHIFT +: 2]]);
          sum -= xtea_pkg::DELTA;
          v0 -= feistel_mix(v1) ^ (sum + key_word[sum[1:0]]);
        end
      end
      res.result_first  = v0;
      res.result_second = v1;
      return res;
    endfunction

    function void note_request(xtea_pkg::in_t req);
      if (req.func == xtea_pkg::FUNC_ENC)
        enc_seen++;
      else
        dec_seen++;
      expected_q.push_back(cipher(req));
    endfunction

    function void check_result(xtea_pkg::out_t got);
      xtea_pkg::out_t exp_blk;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with none expected, actual %h", $time, got);
        fails++;
        return;
      end
      exp_blk = expected_q.pop_front();
      checked++;
      if (got.result_first !== exp_blk.result_first) begin
        $display("%0t ns: result_first expected %h, actual %h",
                 $time, exp_blk.result_first, got.result_first);
        fails++;
      end
      if (got.result_second !== exp_blk.result_second) begin
        $display("%0t ns: result_second expected %h, actual %h",
                 $time, exp_blk.result_second, got.result_second);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [xtea_pkg::WORD_W-1:0]    cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  xtea_pkg::in_t                  in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  xtea_pkg::out_t                 out_data;

  xtea_expect_board board = new();

  // idling switches, set by the stimulus per segment
  bit sender_idle   = 1'b0;
  bit receiver_idle = 1'b0;
  int long_holds_asked = 0;
  int settings_used    = 0;

  xtea_block_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: drive out_stall at the falling edge. Stall in short random bursts while
  // idling is on, with calm stretches in between; serve each long hold asked for.
  initial begin : receiver
    int stall_left;
    int calm_left;
    int holds_served;
    stall_left   = 0;
    calm_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (long_holds_asked != holds_served) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && calm_left == 0 && receiver_idle) begin
        if ($urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 14);
        else if ($urandom_range(0, 15) == 0)
          calm_left = $urandom_range(20, 60);
      end
      if (calm_left > 0)
        calm_left--;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result taken by the receiver against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(out_data);
  end

  // Watchdog: end the run when no channel moves anything for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, board.pending());
    $display("simulation failed");
    $finish;
  end

  function automatic xtea_pkg::in_t make_request(logic f,
                                                 logic [xtea_pkg::WORD_W-1:0] a,
                                                 logic [xtea_pkg::WORD_W-1:0] b);
    xtea_pkg::in_t req;
    req.func         = f;
    req.block_first  = a;
    req.block_second = b;
    return req;
  endfunction

  // random word, biased towards the extremes
  function automatic logic [xtea_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly short round counts to keep the run quick, now and then zero or long ones
  function automatic logic [xtea_pkg::ROUND_W-1:0] pick_rounds();
    case ($urandom_range(0, 9))
      6:       return xtea_pkg::ROUND_W'($urandom_range(9, 31));
      7:       return xtea_pkg::ROUND_RESET;
      8:       return '0;
      9:       return xtea_pkg::ROUND_W'($urandom_range(33, 127));
      default: return xtea_pkg::ROUND_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int sender_gap();
    if (sender_idle && $urandom_range(0, 3) == 0)
      return $urandom_range(1, 14);
    return 0;
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  task automatic send_request(input xtea_pkg::in_t req, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    board.note_request(req);
  endtask

  task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                           input logic [xtea_pkg::WORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the request line and wait until every predicted block has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Round count register: keep junk in the upper data bits, the block uses only 7.
  task automatic write_rounds(input logic [xtea_pkg::ROUND_W-1:0] n);
    write_reg(xtea_pkg::REG_ROUND, {$urandom} & ~32'h7F | {25'd0, n});
    settings_used++;
  endtask

  task automatic write_keys(input logic [xtea_pkg::WORD_W-1:0] k0,
                            input logic [xtea_pkg::WORD_W-1:0] k1,
                            input logic [xtea_pkg::WORD_W-1:0] k2,
                            input logic [xtea_pkg::WORD_W-1:0] k3);
    write_reg(xtea_pkg::REG_KEY0, k0);
    write_reg(xtea_pkg::REG_KEY1, k1);
    write_reg(xtea_pkg::REG_KEY2, k2);
    write_reg(xtea_pkg::REG_KEY3, k3);
  endtask

  initial begin : stimulus
    xtea_pkg::in_t req;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset key of zero and 32 rounds, extreme blocks both ways.
    settings_used = 1;
    send_request(make_request(xtea_pkg::FUNC_ENC, '0, '0), 0);
    send_request(make_request(xtea_pkg::FUNC_DEC, '1, '1), 0);
    send_request(make_request(xtea_pkg::FUNC_ENC, 32'h8000_0000, 32'h0000_0001), 0);
    settle();

    // all-ones key, a single round
    write_keys('1, '1, '1, '1);
    write_rounds(7'd1);
    send_request(make_request(xtea_pkg::FUNC_ENC, '1, '0), 0);
    send_request(make_request(xtea_pkg::FUNC_DEC, '0, '1), 0);
    settle();

    // zero rounds: the block passes through unchanged in both directions
    write_keys($urandom, $urandom, $urandom, $urandom);
    write_rounds('0);
    send_request(make_request(xtea_pkg::FUNC_ENC, 32'h0123_4567, 32'h89AB_CDEF), 0);
    send_request(make_request(xtea_pkg::FUNC_DEC, 32'hFEDC_BA98, 32'h7654_3210), 0);
    settle();

    // full 7-bit round count, well above the usual 32
    write_rounds(7'd127);
    send_request(make_request(xtea_pkg::FUNC_ENC, $urandom, $urandom), 0);
    send_request(make_request(xtea_pkg::FUNC_DEC, $urandom, $urandom), 0);
    settle();

    // 64 rounds, then writes to unused indexes that must leave everything alone
    write_rounds(7'd64);
    send_request(make_request(xtea_pkg::FUNC_ENC, '1, '1), 0);
    settle();
    write_reg(xtea_pkg::REG_ROUND + 3'd1, $urandom);
    write_reg(xtea_pkg::REG_ROUND + 3'd2, '1);
    write_reg(xtea_pkg::REG_ROUND + 3'd3, $urandom);
    send_request(make_request(xtea_pkg::FUNC_DEC, '1, '1), 0);
    send_request(make_request(xtea_pkg::FUNC_ENC, '0, '1), 0);
    settle();

    // Random segments: a fresh key and round count for each; the last few run flat out.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_keys(pick_word(), pick_word(), pick_word(), pick_word());
      if (seg == 1)
        write_rounds(7'd4);
      else
        write_rounds(pick_rounds());
      if ($urandom_range(0, 3) == 0)
        write_reg(xtea_pkg::REG_ROUND + 3'($urandom_range(1, 3)), $urandom);
      receiver_idle = seg < SEGMENTS - 3;
      sender_idle   = (seg < SEGMENTS - 3) && ($urandom_range(0, 2) != 0);
      // hold the receiver off while the sender keeps offering, so the block backs up
      if (seg == 1)
        long_holds_asked++;
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        req = make_request(1'($urandom_range(0, 1)), pick_word(), pick_word());
        send_request(req, (seg == 1) ? 0 : sender_gap());
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d encrypt, %0d decrypt, %0d checked) over %0d round settings,",
             board.enc_seen + board.dec_seen, board.enc_seen, board.dec_seen,
             board.checked, settings_used);
    $display("round counts 0 to 127, extreme keys and blocks, unused indexes and a long hold.");
    if (board.fails == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", board.fails, board.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
